// ===== sv/bsm_pkg.sv =====
package bsm_pkg;

	// action codes of an input item
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_PRG   = 2'd2;
	localparam logic [1:0] ACT_CHR   = 2'd3;

	// register groups selected by address bits 14:13
	localparam logic [1:0] GRP_BANK   = 2'd0;
	localparam logic [1:0] GRP_MIRROR = 2'd1;
	localparam logic [1:0] GRP_LATCH  = 2'd2;
	localparam logic [1:0] GRP_IRQ_EN = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
	localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
	localparam logic [1:0] CFG_CHR_RAM   = 2'd2;

	// widths
	localparam int ACT_W   = 2;
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int OFF_W   = 19;
	localparam int PCNT_W  = 7;
	localparam int CCNT_W  = 9;
	localparam int CIDX_W  = 2;
	localparam int STEP_W  = 3;

	localparam logic [PCNT_W-1:0] PRG_COUNT_MAX   = 7'd64;
	localparam logic [PCNT_W-1:0] PRG_COUNT_RESET = 7'd2;
	localparam logic [CCNT_W-1:0] CHR_COUNT_RESET = 9'd8;
	localparam logic [STEP_W-1:0] STEP_LAST       = 3'd7;

	// commands from controller to datapath
	typedef struct packed {
		logic load_in;
		logic exec;
		logic div_start;
		logic div_step;
		logic load_out;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic xlate;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

// ===== sv/bank_switch_mapper_scanline_irq.sv =====
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     action, address, value
// out       output     out_valid / out_ready   mapped_offset, irq_line, mirroring
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a write or tick item passes through accept, execute and result load
// a translate item passes through accept, execute, a bit-serial bank modulo and result load
// one item is in work at a time; the next may be accepted once the result sits
// in the output register, and a stalled output holds the finished item
// reset gives the power-on bank counts and clears all mapper state at once
// cfg_ready is always high; a config write is registered whenever cfg_valid is high
module bank_switch_mapper_scanline_irq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bsm_pkg::ACT_W-1:0]  action,
	input  logic [bsm_pkg::ADDR_W-1:0] address,
	input  logic [bsm_pkg::DATA_W-1:0] value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bsm_pkg::OFF_W-1:0]  mapped_offset,
	output logic                       irq_line,
	output logic                       mirroring,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bsm_pkg::CIDX_W-1:0] cfg_index,
	input  logic [bsm_pkg::CCNT_W-1:0] cfg_data
);

	bsm_pkg::cmd_t cmd;
	bsm_pkg::sts_t sts;
	logic          ctrl_in_ready;

	assign cfg_ready = 1'b1;
	assign in_ready  = ctrl_in_ready;

	// sequencer
	bsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (ctrl_in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// mapper registers, modulo unit and output register
	bsm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.address       (address),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mapped_offset (mapped_offset),
		.irq_line      (irq_line),
		.mirroring     (mirroring)
	);

`ifndef SYNTHESIS
	// an accepted item blocks further input until its result is loaded
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while one is in work");

	// no accepted item reaches the output slot before its execute step
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !cmd.load_out)
		else $error("result loaded in the cycle after accept");
`endif

endmodule

// ===== sv/bsm_ctrl.sv =====
module bsm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bsm_pkg::sts_t sts,
	output bsm_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = sts.xlate ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// a result is only written once the output slot is free
	a_load_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.out_busy)
		else $error("result loaded into a busy output slot");

	// the divider only steps for translate items
	a_div_xlate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && !sts.xlate) |=> !cmd.div_step)
		else $error("divider stepped for a write or tick item");
`endif

endmodule

// ===== sv/bsm_dp.sv =====
module bsm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bsm_pkg::cmd_t                      cmd,
	output bsm_pkg::sts_t                      sts,
	input  logic                               cfg_valid,
	input  logic [bsm_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [bsm_pkg::CCNT_W-1:0]         cfg_data,
	input  logic [bsm_pkg::ACT_W-1:0]          action,
	input  logic [bsm_pkg::ADDR_W-1:0]         address,
	input  logic [bsm_pkg::DATA_W-1:0]         value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bsm_pkg::OFF_W-1:0]          mapped_offset,
	output logic                               irq_line,
	output logic                               mirroring
);

	// configuration
	logic [bsm_pkg::PCNT_W-1:0] prg_count_q;
	logic [bsm_pkg::CCNT_W-1:0] chr_count_q;
	logic                       chr_ram_q;

	// input item
	logic [bsm_pkg::ACT_W-1:0]  act_q;
	logic [bsm_pkg::ADDR_W-1:0] addr_q;
	logic [bsm_pkg::DATA_W-1:0] val_q;

	// mapper state
	logic [7:0] bank_sel_q;
	logic [7:0] bank_q [8];
	logic [7:0] latch_q;
	logic [7:0] count_q;
	logic       reload_q;
	logic       irq_en_q;
	logic       irq_pend_q;
	logic       mirror_q;

	// divider
	logic [bsm_pkg::CCNT_W-1:0] div_q;
	logic [7:0]                 dvd_q;
	logic [bsm_pkg::CCNT_W-1:0] rem_q;
	logic [bsm_pkg::STEP_W-1:0] step_q;

	// output register
	logic                       out_valid_q;
	logic [bsm_pkg::OFF_W-1:0]  offset_q;
	logic                       irq_q;
	logic                       mirror_out_q;

	logic       is_write;
	logic       is_tick;
	logic [1:0] grp;
	logic       odd;
	logic [1:0] win;
	logic [7:0] count_next;

	logic [bsm_pkg::PCNT_W-1:0] prg_n;
	logic [bsm_pkg::PCNT_W-1:0] prg_second_last;
	logic [bsm_pkg::PCNT_W-1:0] prg_last;
	logic [bsm_pkg::CCNT_W-1:0] chr_n;
	logic [12:0]                chr_a;
	logic [7:0]                 prg_src;
	logic [7:0]                 chr_src;

	logic [bsm_pkg::CCNT_W:0]   trial;
	logic [bsm_pkg::CCNT_W:0]   trial_sub;

	logic [5:0]                 prg_bank;
	logic [bsm_pkg::OFF_W-1:0]  offset_d;

	assign is_write = (act_q == bsm_pkg::ACT_WRITE);
	assign is_tick  = (act_q == bsm_pkg::ACT_TICK);
	assign grp      = addr_q[14:13];
	assign odd      = addr_q[0];
	assign win      = addr_q[14:13];

	// effective bank counts
	always_comb begin
		if (prg_count_q == '0) begin
			prg_n = 7'd1;
		end else if (prg_count_q > bsm_pkg::PRG_COUNT_MAX) begin
			prg_n = bsm_pkg::PRG_COUNT_MAX;
		end else begin
			prg_n = prg_count_q;
		end
		prg_second_last = (prg_n >= 7'd2) ? prg_n - 7'd2 : 7'd0;
		prg_last        = prg_n - 7'd1;
		chr_n           = (chr_count_q == '0) ? 9'd1 : chr_count_q;
	end

	// bank number ahead of the modulo
	always_comb begin
		prg_src = (win == 2'd1) ? {2'b00, bank_q[7][5:0]} : {2'b00, bank_q[6][5:0]};
		chr_a   = addr_q[12:0] ^ {bank_sel_q[7], 12'h000};
		if (!chr_a[12] && !chr_a[11]) begin
			chr_src = {bank_q[0][7:1], chr_a[10]};
		end else if (!chr_a[12]) begin
			chr_src = {bank_q[1][7:1], chr_a[10]};
		end else begin
			chr_src = bank_q[3'd2 + {1'b0, chr_a[11:10]}];
		end
	end

	// counter value after a tick
	assign count_next = (count_q == 8'd0 || reload_q) ? latch_q : count_q - 8'd1;

	// configuration port, taken at any time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= bsm_pkg::PRG_COUNT_RESET;
			chr_count_q <= bsm_pkg::CHR_COUNT_RESET;
			chr_ram_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bsm_pkg::CFG_PRG_COUNT: prg_count_q <= cfg_data[bsm_pkg::PCNT_W-1:0];
				bsm_pkg::CFG_CHR_COUNT: chr_count_q <= cfg_data;
				bsm_pkg::CFG_CHR_RAM:   chr_ram_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q  <= action;
			addr_q <= address;
			val_q  <= value;
		end
	end

	// register writes and scanline ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_sel_q <= '0;
			for (int i = 0; i < 8; i++) begin
				bank_q[i] <= '0;
			end
			latch_q    <= '0;
			count_q    <= '0;
			reload_q   <= 1'b0;
			irq_en_q   <= 1'b0;
			irq_pend_q <= 1'b0;
			mirror_q   <= 1'b0;
		end else if (cmd.exec && is_write) begin
			case (grp)
				bsm_pkg::GRP_BANK: begin
					if (odd) begin
						bank_q[bank_sel_q[2:0]] <= val_q;
					end else begin
						bank_sel_q <= val_q;
					end
				end
				bsm_pkg::GRP_MIRROR: begin
					if (!odd) begin
						mirror_q <= val_q[0];
					end
				end
				bsm_pkg::GRP_LATCH: begin
					if (odd) begin
						reload_q <= 1'b1;
					end else begin
						latch_q <= val_q;
					end
				end
				bsm_pkg::GRP_IRQ_EN: begin
					if (odd) begin
						irq_en_q <= 1'b1;
					end else begin
						irq_en_q   <= 1'b0;
						irq_pend_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.exec && is_tick) begin
			count_q  <= count_next;
			reload_q <= 1'b0;
			if (count_next == 8'd0 && irq_en_q) begin
				irq_pend_q <= 1'b1;
			end
		end
	end

	// restoring modulo, one dividend bit per cycle
	assign trial     = {rem_q, dvd_q[7]};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_q  <= (act_q == bsm_pkg::ACT_PRG) ? {2'b00, prg_n} : chr_n;
			dvd_q  <= (act_q == bsm_pkg::ACT_PRG) ? prg_src : chr_src;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[6:0], 1'b0};
			rem_q  <= (trial >= {1'b0, div_q}) ? trial_sub[bsm_pkg::CCNT_W-1:0]
			                                    : trial[bsm_pkg::CCNT_W-1:0];
			step_q <= step_q + 3'd1;
		end
	end

	// final offset
	always_comb begin
		case (win)
			2'd0:    prg_bank = bank_sel_q[6] ? prg_second_last[5:0] : rem_q[5:0];
			2'd1:    prg_bank = rem_q[5:0];
			2'd2:    prg_bank = bank_sel_q[6] ? rem_q[5:0] : prg_second_last[5:0];
			default: prg_bank = prg_last[5:0];
		endcase
		case (act_q)
			bsm_pkg::ACT_PRG: offset_d = {prg_bank, addr_q[12:0]};
			bsm_pkg::ACT_CHR: begin
				if (chr_ram_q) begin
					offset_d = {6'd0, addr_q[12:0]};
				end else begin
					offset_d = {1'b0, rem_q[7:0], chr_a[9:0]};
				end
			end
			default: offset_d = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			offset_q     <= offset_d;
			irq_q        <= irq_pend_q;
			mirror_out_q <= mirror_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign mapped_offset = offset_q;
	assign irq_line      = irq_q;
	assign mirroring     = mirror_out_q;

	assign sts.xlate    = act_q[1];
	assign sts.div_last = (step_q == bsm_pkg::STEP_LAST);
	assign sts.out_busy = out_valid_q && !out_ready;

`ifndef SYNTHESIS
	// the running remainder always stays below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) |-> (rem_q < div_q))
		else $error("modulo remainder out of range");

	// a pending interrupt is only cleared by a disable write
	a_irq_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(irq_pend_q) |-> $past(cmd.exec && is_write && grp == bsm_pkg::GRP_IRQ_EN && !odd))
		else $error("pending interrupt cleared without a disable write");

	// state is left alone by translate items
	a_xlate_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && sts.xlate) |=> ($stable(count_q) && $stable(bank_sel_q)))
		else $error("translate item changed mapper state");
`endif

endmodule
